>>> design/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define XCRC_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define XCRC_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> design/xcrc_pkg.sv
package xcrc_pkg;

  localparam logic [1:0] ACT_BYTE    = 2'd0;
  localparam logic [1:0] ACT_TIMEOUT = 2'd1;
  localparam logic [1:0] ACT_START   = 2'd2;

  localparam logic [7:0] CH_SOH = 8'h01;
  localparam logic [7:0] CH_EOT = 8'h04;
  localparam logic [7:0] CH_ACK = 8'h06;
  localparam logic [7:0] CH_NAK = 8'h15;
  localparam logic [7:0] CH_CAN = 8'h18;
  localparam logic [7:0] CH_C   = 8'h43;

  localparam logic [1:0] VER_NONE    = 2'd0;
  localparam logic [1:0] VER_COMMIT  = 2'd1;
  localparam logic [1:0] VER_DISCARD = 2'd2;

  localparam logic [1:0] ST_RUNNING   = 2'd0;
  localparam logic [1:0] ST_COMPLETED = 2'd1;
  localparam logic [1:0] ST_ABORTED   = 2'd2;
  localparam logic [1:0] ST_CANCELLED = 2'd3;

  localparam logic [7:0]  RETRY_LIMIT_RESET = 8'd10;
  localparam logic [15:0] CRC_POLY          = 16'h1021;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_LEAD  = 3'b010,
    PH_FRAME = 3'b100
  } phase_t;

  typedef struct packed {
    logic       reply_valid;
    logic [7:0] reply_byte;
    logic       purge_request;
    logic       data_valid;
    logic [7:0] data_byte;
    logic [1:0] block_verdict;
    logic [1:0] session_status;
    logic [7:0] expected_block;
  } result_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

>>> design/xmodem_crc_receiver.sv
// XMODEM-CRC receiver.
// Input beats (s_axis) carry one event each: tuser selects a received byte,
// a receive timeout or a start command, tdata holds the byte. Every input
// beat yields exactly one result beat on m_axis with the reply byte to send
// ('C', ACK or NAK) and its purge flag, a tentative payload byte, the frame
// verdict (commit or discard), the session status and the next block number.
// The retry limit is written on the cfg channel (cfg_ready is always high)
// while no beat is in flight; the user ensures it, the block does not enforce it.
// It resets to 10. A taken beat's result is registered in the result buffer
// and is on m_axis in the cycle after if no older result waits there.
// Throughput: one beat per cycle while s_axis_tready is high; the frame state
// updates per beat with a byte-wide CRC step. A two-entry result buffer parts
// the sides: when m_axis stalls, s_axis keeps taking beats until both entries
// are full, then drops tready. Reset (rst, synchronous) empties the buffer,
// sets the session to idle, the expected block to 1 and the retry count to 0.
module xmodem_crc_receiver #(
  parameter int BLOCK_BYTES = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic [1:0]  s_axis_tuser,   // [1:0] action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] reply_byte, [8] purge_request, [16:9] data_byte, [18:17] block_verdict,
  // [20:19] session_status, [28:21] expected_block, [31:29] zero
  output logic [31:0] m_axis_tdata,
  output logic [1:0]  m_axis_tuser,   // [0] reply_valid, [1] data_valid
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data        // retry_limit
);

  logic [7:0]        retry_limit;
  logic              accept;
  xcrc_pkg::result_t res;
  xcrc_pkg::result_t out_res;

  assign cfg_ready = 1'b1;
  assign accept    = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      retry_limit <= xcrc_pkg::RETRY_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      retry_limit <= cfg_data;
    end
  end

  xcrc_ctrl #(
    .BLOCK_BYTES(BLOCK_BYTES)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .action     (s_axis_tuser),
    .rx_byte    (s_axis_tdata),
    .retry_limit(retry_limit),
    .res        (res)
  );

  xcrc_obuf u_obuf (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_data  (res),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_data (out_res)
  );

  assign m_axis_tdata = {3'b000, out_res.expected_block, out_res.session_status,
                         out_res.block_verdict, out_res.data_byte,
                         out_res.purge_request, out_res.reply_byte};
  assign m_axis_tuser = {out_res.data_valid, out_res.reply_valid};

endmodule

>>> design/xcrc_ctrl.sv
`include "assert_macros.svh"

module xcrc_ctrl #(
  parameter int BLOCK_BYTES = 128
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [1:0]         action,
  input  logic [7:0]         rx_byte,
  input  logic [7:0]         retry_limit,
  output xcrc_pkg::result_t  res
);

  localparam int IW = $clog2(BLOCK_BYTES + 4);
  localparam logic [IW-1:0] IDX_NUM    = IW'(0);
  localparam logic [IW-1:0] IDX_COMP   = IW'(1);
  localparam logic [IW-1:0] IDX_CRC_HI = IW'(BLOCK_BYTES + 2);

  xcrc_pkg::phase_t phase, phase_next;
  logic [IW-1:0] frame_byte_index, frame_byte_index_next;
  logic [7:0]  next_block_number, next_block_number_next;
  logic [7:0]  retry_count, retry_count_next;
  logic [7:0]  received_number, received_number_next;
  logic [7:0]  received_complement, received_complement_next;
  logic [15:0] running_crc, running_crc_next;
  logic [7:0]  received_crc_high, received_crc_high_next;

  logic [7:0] retry_sat;
  logic       do_fail;
  logic       is_dup;
  logic       is_bad;

  assign retry_sat = (retry_count == 8'hFF) ? 8'hFF : retry_count + 8'd1;
  assign is_dup = (received_number < next_block_number) &&
                  (received_complement == ~received_number);
  assign is_bad = (received_number != next_block_number) ||
                  (received_complement != ~next_block_number) ||
                  (running_crc != {received_crc_high, rx_byte});

  always_comb begin
    res                      = '0;
    do_fail                  = 1'b0;
    phase_next               = phase;
    frame_byte_index_next    = frame_byte_index;
    next_block_number_next   = next_block_number;
    retry_count_next         = retry_count;
    received_number_next     = received_number;
    received_complement_next = received_complement;
    running_crc_next         = running_crc;
    received_crc_high_next   = received_crc_high;

    priority if (action == xcrc_pkg::ACT_START) begin
      phase_next             = xcrc_pkg::PH_LEAD;
      next_block_number_next = 8'd1;
      retry_count_next       = 8'd0;
      frame_byte_index_next  = '0;
      res.reply_valid        = 1'b1;
      res.reply_byte         = xcrc_pkg::CH_C;
      res.purge_request      = 1'b1;
    end else if (action != xcrc_pkg::ACT_BYTE && action != xcrc_pkg::ACT_TIMEOUT) begin
      // drop unknown action
    end else if (phase == xcrc_pkg::PH_LEAD) begin
      priority if (action == xcrc_pkg::ACT_TIMEOUT) begin
        do_fail = 1'b1;
      end else if (rx_byte == xcrc_pkg::CH_EOT) begin
        res.reply_valid    = 1'b1;
        res.reply_byte     = xcrc_pkg::CH_ACK;
        res.session_status = xcrc_pkg::ST_COMPLETED;
        phase_next         = xcrc_pkg::PH_IDLE;
      end else if (rx_byte == xcrc_pkg::CH_CAN) begin
        res.reply_valid    = 1'b1;
        res.reply_byte     = xcrc_pkg::CH_ACK;
        res.session_status = xcrc_pkg::ST_CANCELLED;
        phase_next         = xcrc_pkg::PH_IDLE;
      end else if (rx_byte == xcrc_pkg::CH_SOH) begin
        phase_next            = xcrc_pkg::PH_FRAME;
        frame_byte_index_next = '0;
        running_crc_next      = 16'h0000;
      end else begin
        do_fail = 1'b1;
      end
    end else if (phase == xcrc_pkg::PH_FRAME) begin
      priority if (action == xcrc_pkg::ACT_TIMEOUT) begin
        res.block_verdict = xcrc_pkg::VER_DISCARD;
        do_fail           = 1'b1;
      end else if (frame_byte_index == IDX_NUM) begin
        received_number_next  = rx_byte;
        frame_byte_index_next = IDX_COMP;
      end else if (frame_byte_index == IDX_COMP) begin
        received_complement_next = rx_byte;
        frame_byte_index_next    = frame_byte_index + IW'(1);
      end else if (frame_byte_index < IDX_CRC_HI) begin
        res.data_valid        = 1'b1;
        res.data_byte         = rx_byte;
        running_crc_next      = xcrc_pkg::crc_byte(running_crc, rx_byte);
        frame_byte_index_next = frame_byte_index + IW'(1);
      end else if (frame_byte_index == IDX_CRC_HI) begin
        received_crc_high_next = rx_byte;
        frame_byte_index_next  = frame_byte_index + IW'(1);
      end else begin
        frame_byte_index_next = '0;
        priority if (is_dup) begin
          res.reply_valid   = 1'b1;
          res.reply_byte    = xcrc_pkg::CH_ACK;
          res.block_verdict = xcrc_pkg::VER_DISCARD;
          retry_count_next  = 8'd0;
          phase_next        = xcrc_pkg::PH_LEAD;
        end else if (is_bad) begin
          res.block_verdict = xcrc_pkg::VER_DISCARD;
          do_fail           = 1'b1;
        end else begin
          res.reply_valid        = 1'b1;
          res.reply_byte         = xcrc_pkg::CH_ACK;
          res.block_verdict      = xcrc_pkg::VER_COMMIT;
          next_block_number_next = next_block_number + 8'd1;
          retry_count_next       = 8'd0;
          phase_next             = xcrc_pkg::PH_LEAD;
        end
      end
    end else begin
      // idle: ignore bytes and timeouts
    end

    if (do_fail) begin
      res.reply_valid   = 1'b1;
      res.reply_byte    = xcrc_pkg::CH_NAK;
      res.purge_request = 1'b1;
      retry_count_next  = retry_sat;
      phase_next        = xcrc_pkg::PH_LEAD;
      if (retry_sat > retry_limit) begin
        res.session_status = xcrc_pkg::ST_ABORTED;
        phase_next         = xcrc_pkg::PH_IDLE;
      end
    end

    res.expected_block = next_block_number_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase               <= xcrc_pkg::PH_IDLE;
      frame_byte_index    <= '0;
      next_block_number   <= 8'd1;
      retry_count         <= 8'd0;
      received_number     <= 8'd0;
      received_complement <= 8'd0;
      running_crc         <= 16'h0000;
      received_crc_high   <= 8'd0;
    end else if (accept) begin
      phase               <= phase_next;
      frame_byte_index    <= frame_byte_index_next;
      next_block_number   <= next_block_number_next;
      retry_count         <= retry_count_next;
      received_number     <= received_number_next;
      received_complement <= received_complement_next;
      running_crc         <= running_crc_next;
      received_crc_high   <= received_crc_high_next;
    end
  end

  `XCRC_ASSERT(a_end_goes_idle, clk, rst, accept && res.session_status != xcrc_pkg::ST_RUNNING |=> phase == xcrc_pkg::PH_IDLE, "session end did not return to idle")
  `XCRC_ASSERT(a_commit_clears_retry, clk, rst, accept && res.block_verdict == xcrc_pkg::VER_COMMIT |=> retry_count == 8'd0, "commit left retries pending")
  `XCRC_ASSERT(a_data_in_frame, clk, rst, res.data_valid |-> phase == xcrc_pkg::PH_FRAME, "payload byte outside a frame")

endmodule

>>> design/xcrc_obuf.sv
`include "assert_macros.svh"

module xcrc_obuf (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  xcrc_pkg::result_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output xcrc_pkg::result_t out_data
);

  xcrc_pkg::result_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       wr;
  logic       rd;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = mem[rd_ptr];
  assign wr        = in_valid && in_ready;
  assign rd        = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wr_ptr] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, wr} - {1'b0, rd};
    end
  end

  `XCRC_ASSERT_ALWAYS(a_count_range, clk, rst || count != 2'd3, "result buffer count out of range")
  `XCRC_ASSERT(a_fill_tracks_ptrs, clk, rst, count == 2'd1 |-> wr_ptr != rd_ptr, "buffer pointers disagree with count")
  `XCRC_ASSERT(a_push_only_grows, clk, rst, wr && !rd |=> count == $past(count) + 2'd1, "push did not grow buffer")

endmodule

>>> tb/xmodem_crc_receiver_checker.sv
`timescale 1ns / 1ps

package xcrc_tb_pkg;

  localparam int         FRAME_PAYLOAD = 128;
  localparam logic [1:0] ACT_NOP       = 2'd3;

  function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = acc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[15] ^ b[i];
      c  = {c[14:0], 1'b0} ^ (fb ? xcrc_pkg::CRC_POLY : 16'h0000);
    end
    return c;
  endfunction

endpackage

module xmodem_crc_receiver_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,
  input  logic [1:0]  m_tuser,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  output int          errors,
  output int          pending,
  output logic [7:0]  next_block,
  output logic        live
);

  xcrc_pkg::phase_t  session_phase;
  logic [15:0]       frame_pos;
  logic [7:0]        blk_expected;
  logic [7:0]        fail_streak;
  logic [7:0]        retry_cap;
  logic [7:0]        hdr_number;
  logic [7:0]        hdr_complement;
  logic [7:0]        crc_hi;
  logic [15:0]       payload_crc;
  xcrc_pkg::result_t reply_queue[$];
  int                fail_count;

  assign errors = fail_count;

  task automatic count_failure(inout xcrc_pkg::result_t r);
    r.reply_valid   = 1'b1;
    r.reply_byte    = xcrc_pkg::CH_NAK;
    r.purge_request = 1'b1;
    if (fail_streak != 8'hFF) fail_streak++;
    session_phase = xcrc_pkg::PH_LEAD;
    if (fail_streak > retry_cap) begin
      r.session_status = xcrc_pkg::ST_ABORTED;
      session_phase    = xcrc_pkg::PH_IDLE;
    end
  endtask

  task automatic advance_session(input logic [1:0] act, input logic [7:0] b,
                                 output xcrc_pkg::result_t r);
    r = '0;
    if (act == xcrc_pkg::ACT_START) begin
      session_phase   = xcrc_pkg::PH_LEAD;
      blk_expected    = 8'd1;
      fail_streak     = '0;
      frame_pos       = '0;
      r.reply_valid   = 1'b1;
      r.reply_byte    = xcrc_pkg::CH_C;
      r.purge_request = 1'b1;
    end else if (act == xcrc_pkg::ACT_TIMEOUT && session_phase == xcrc_pkg::PH_FRAME) begin
      r.block_verdict = xcrc_pkg::VER_DISCARD;
      count_failure(r);
    end else if (act == xcrc_pkg::ACT_TIMEOUT && session_phase == xcrc_pkg::PH_LEAD) begin
      count_failure(r);
    end else if (act == xcrc_pkg::ACT_BYTE && session_phase == xcrc_pkg::PH_LEAD) begin
      unique case (b)
        xcrc_pkg::CH_EOT: begin
          r.reply_valid    = 1'b1;
          r.reply_byte     = xcrc_pkg::CH_ACK;
          r.session_status = xcrc_pkg::ST_COMPLETED;
          session_phase    = xcrc_pkg::PH_IDLE;
        end
        xcrc_pkg::CH_CAN: begin
          r.reply_valid    = 1'b1;
          r.reply_byte     = xcrc_pkg::CH_ACK;
          r.session_status = xcrc_pkg::ST_CANCELLED;
          session_phase    = xcrc_pkg::PH_IDLE;
        end
        xcrc_pkg::CH_SOH: begin
          session_phase = xcrc_pkg::PH_FRAME;
          frame_pos     = '0;
          payload_crc   = '0;
        end
        default: count_failure(r);
      endcase
    end else if (act == xcrc_pkg::ACT_BYTE && session_phase == xcrc_pkg::PH_FRAME) begin
      if (frame_pos == 0) begin
        hdr_number = b;
        frame_pos  = 16'd1;
      end else if (frame_pos == 1) begin
        hdr_complement = b;
        frame_pos      = 16'd2;
      end else if (frame_pos < xcrc_tb_pkg::FRAME_PAYLOAD + 2) begin
        r.data_valid = 1'b1;
        r.data_byte  = b;
        payload_crc  = xcrc_tb_pkg::crc16_step(payload_crc, b);
        frame_pos++;
      end else if (frame_pos == xcrc_tb_pkg::FRAME_PAYLOAD + 2) begin
        crc_hi = b;
        frame_pos++;
      end else begin
        frame_pos = '0;
        if (hdr_number < blk_expected && hdr_complement == ~hdr_number) begin
          r.reply_valid   = 1'b1;
          r.reply_byte    = xcrc_pkg::CH_ACK;
          r.block_verdict = xcrc_pkg::VER_DISCARD;
          fail_streak     = '0;
          session_phase   = xcrc_pkg::PH_LEAD;
        end else if (hdr_number != blk_expected || hdr_complement != ~blk_expected ||
                     payload_crc != {crc_hi, b}) begin
          r.block_verdict = xcrc_pkg::VER_DISCARD;
          count_failure(r);
        end else begin
          r.reply_valid   = 1'b1;
          r.reply_byte    = xcrc_pkg::CH_ACK;
          r.block_verdict = xcrc_pkg::VER_COMMIT;
          blk_expected++;
          fail_streak     = '0;
          session_phase   = xcrc_pkg::PH_LEAD;
        end
      end
    end
    r.expected_block = blk_expected;
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  initial begin
    fail_count = 0;
    pending    = 0;
    next_block = 8'd1;
    live       = 1'b0;
  end

  always @(posedge clk) begin : watch
    xcrc_pkg::result_t seen;
    xcrc_pkg::result_t want;
    xcrc_pkg::result_t made;
    if (rst) begin
      session_phase  = xcrc_pkg::PH_IDLE;
      frame_pos      = '0;
      blk_expected   = 8'd1;
      fail_streak    = '0;
      retry_cap      = xcrc_pkg::RETRY_LIMIT_RESET;
      hdr_number     = '0;
      hdr_complement = '0;
      crc_hi         = '0;
      payload_crc    = '0;
      reply_queue.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        seen.reply_valid    = m_tuser[0];
        seen.data_valid     = m_tuser[1];
        seen.reply_byte     = m_tdata[7:0];
        seen.purge_request  = m_tdata[8];
        seen.data_byte      = m_tdata[16:9];
        seen.block_verdict  = m_tdata[18:17];
        seen.session_status = m_tdata[20:19];
        seen.expected_block = m_tdata[28:21];
        if (reply_queue.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result beat: expected none, got %0h/%0h",
                   $time, m_tuser, m_tdata);
        end else begin
          want = reply_queue.pop_front();
          check_field("reply_valid", 8'(want.reply_valid), 8'(seen.reply_valid));
          check_field("reply_byte", want.reply_byte, seen.reply_byte);
          check_field("purge_request", 8'(want.purge_request), 8'(seen.purge_request));
          check_field("data_valid", 8'(want.data_valid), 8'(seen.data_valid));
          check_field("data_byte", want.data_byte, seen.data_byte);
          check_field("block_verdict", 8'(want.block_verdict), 8'(seen.block_verdict));
          check_field("session_status", 8'(want.session_status),
                      8'(seen.session_status));
          check_field("expected_block", want.expected_block, seen.expected_block);
        end
      end
      if (s_tvalid && s_tready) begin
        advance_session(s_tuser, s_tdata, made);
        reply_queue.push_back(made);
      end
      if (cfg_valid && cfg_ready) retry_cap = cfg_data;
    end
    pending    = reply_queue.size();
    next_block = blk_expected;
    live       = (session_phase != xcrc_pkg::PH_IDLE);
  end

endmodule

>>> tb/xmodem_crc_receiver_tb.sv
`timescale 1ns / 1ps

module xmodem_crc_receiver_tb;

  localparam int STALL_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_tdata;
  logic [1:0]  s_tuser;
  logic        m_axis_tvalid;
  logic        m_tready;
  logic [31:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [7:0]  cfg_data;

  int          error_count;
  int          pending_count;
  logic [7:0]  session_block;
  logic        session_live;

  int          burst_left;
  int          gap_max;
  int          useful;
  int          idle_cycles;
  bit          hold_go;

  xmodem_crc_receiver #(.BLOCK_BYTES(xcrc_tb_pkg::FRAME_PAYLOAD)) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_tdata),
    .s_axis_tuser (s_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  xmodem_crc_receiver_checker chk (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_axis_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_axis_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_axis_tdata),
    .m_tuser   (m_axis_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .errors    (error_count),
    .pending   (pending_count),
    .next_block(session_block),
    .live      (session_live)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic send(input logic [1:0] act, input logic [7:0] b);
    int gap;
    if (act == xcrc_pkg::ACT_START || (act != xcrc_tb_pkg::ACT_NOP && session_live)) useful++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if (gap_max > 0) begin
        s_tvalid <= 1'b0;
        gap = $urandom_range(1, gap_max);
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    wait (pending_count == 0);
    @(negedge clk);
  endtask

  task automatic write_limit(input logic [7:0] v);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // cut_at < 0 sends the whole frame; otherwise cut_act replaces that byte and ends it
  task automatic send_frame(input logic [7:0] num, input logic [7:0] comp, input bit spoil,
                            input int cut_at, input logic [1:0] cut_act);
    logic [15:0] crc;
    logic [7:0]  b;
    int          fill;
    int          i;
    crc  = 16'h0000;
    fill = $urandom_range(0, 5);
    send(xcrc_pkg::ACT_BYTE, xcrc_pkg::CH_SOH);
    for (i = 0; i < xcrc_tb_pkg::FRAME_PAYLOAD + 4 && i != cut_at; i++) begin
      if (i == 0) begin
        b = num;
      end else if (i == 1) begin
        b = comp;
      end else if (i < xcrc_tb_pkg::FRAME_PAYLOAD + 2) begin
        b   = (fill == 0) ? 8'h00 : (fill == 1) ? 8'hFF : 8'($urandom);
        crc = xcrc_tb_pkg::crc16_step(crc, b);
      end else if (i == xcrc_tb_pkg::FRAME_PAYLOAD + 2) begin
        if (spoil) crc = crc ^ 16'($urandom_range(1, 65535));
        b = crc[15:8];
      end else begin
        b = crc[7:0];
      end
      send(xcrc_pkg::ACT_BYTE, b);
    end
    if (cut_at >= 0) send(cut_act, 8'($urandom));
  endtask

  function automatic int pick_cut();
    if ($urandom_range(0, 4) != 0) return $urandom_range(0, 5);
    return $urandom_range(0, xcrc_tb_pkg::FRAME_PAYLOAD + 3);
  endfunction

  task automatic mix(input int target);
    int         stop_at;
    int         pick;
    logic [7:0] num;
    logic [7:0] comp;
    stop_at = useful + target;
    send(xcrc_pkg::ACT_START, 8'($urandom));
    send_frame(session_block, ~session_block, 1'b0, -1, xcrc_pkg::ACT_TIMEOUT);
    while (useful < stop_at) begin
      if (!session_live) begin
        pick = $urandom_range(0, 9);
        if (pick < 7) send(xcrc_pkg::ACT_START, 8'($urandom));
        else if (pick == 7) send(xcrc_pkg::ACT_BYTE, 8'($urandom));
        else if (pick == 8) send(xcrc_pkg::ACT_TIMEOUT, 8'($urandom));
        else send(xcrc_tb_pkg::ACT_NOP, 8'($urandom));
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 9) begin
          send_frame(session_block, ~session_block, 1'b0, -1, xcrc_pkg::ACT_TIMEOUT);
        end else if (pick < 12) begin
          send_frame(session_block, ~session_block, 1'b1, -1, xcrc_pkg::ACT_TIMEOUT);
        end else if (pick < 15) begin
          num  = 8'($urandom);
          comp = $urandom_range(0, 1) ? ~num : 8'($urandom);
          send_frame(num, comp, 1'($urandom_range(0, 1)), -1, xcrc_pkg::ACT_TIMEOUT);
        end else if (pick < 18) begin
          num = (session_block == 0) ? 8'd0 : 8'($urandom_range(0, session_block - 1));
          send_frame(num, ~num, 1'($urandom_range(0, 1)), -1, xcrc_pkg::ACT_TIMEOUT);
        end else if (pick < 38) begin
          send_frame(session_block, ~session_block, 1'b0, pick_cut(), xcrc_pkg::ACT_TIMEOUT);
        end else if (pick < 42) begin
          send_frame(session_block, ~session_block, 1'b0, pick_cut(), xcrc_pkg::ACT_START);
        end else if (pick < 60) begin
          send(xcrc_pkg::ACT_BYTE, 8'($urandom));
        end else if (pick < 74) begin
          send(xcrc_pkg::ACT_TIMEOUT, 8'($urandom));
        end else if (pick < 78) begin
          send(xcrc_pkg::ACT_BYTE, xcrc_pkg::CH_EOT);
        end else if (pick < 81) begin
          send(xcrc_pkg::ACT_BYTE, xcrc_pkg::CH_CAN);
        end else if (pick < 85) begin
          send(xcrc_pkg::ACT_START, 8'($urandom));
        end else begin
          send(xcrc_tb_pkg::ACT_NOP, 8'($urandom));
        end
      end
    end
  endtask

  initial begin
    int mode;
    int len;
    m_tready = 1'b0;
    forever begin
      if (hold_go) begin
        hold_go = 1'b0;
        @(negedge clk);
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        mode = $urandom_range(0, 2);
        len  = $urandom_range(10, 80);
        repeat (len) begin
          @(negedge clk);
          case (mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            default: m_tready <= ($urandom_range(0, 3) == 0);
          endcase
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_axis_tready) || (m_axis_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == STALL_LIMIT) begin
      $display("** xmodem_crc_receiver: FAILED **");
      $finish;
    end
  end

  initial begin
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = 8'h00;
    s_tuser     = xcrc_pkg::ACT_BYTE;
    cfg_valid   = 1'b0;
    cfg_data    = 8'h00;
    burst_left  = 0;
    gap_max     = 8;
    useful      = 0;
    idle_cycles = 0;
    hold_go     = 1'b0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    send(xcrc_pkg::ACT_BYTE, 8'h00);
    send(xcrc_pkg::ACT_BYTE, 8'hFF);
    send(xcrc_pkg::ACT_TIMEOUT, 8'h00);
    send(xcrc_tb_pkg::ACT_NOP, 8'hFF);
    send(xcrc_pkg::ACT_START, 8'h00);
    send(xcrc_tb_pkg::ACT_NOP, 8'h5A);
    send(xcrc_pkg::ACT_TIMEOUT, 8'hFF);
    send(xcrc_pkg::ACT_BYTE, 8'hFF);
    send(xcrc_pkg::ACT_BYTE, xcrc_pkg::CH_EOT);
    send(xcrc_pkg::ACT_START, 8'hFF);
    send(xcrc_pkg::ACT_BYTE, xcrc_pkg::CH_CAN);
    send(xcrc_pkg::ACT_START, 8'h00);
    send(xcrc_pkg::ACT_BYTE, xcrc_pkg::CH_SOH);
    send(xcrc_pkg::ACT_BYTE, 8'h01);
    send(xcrc_pkg::ACT_BYTE, 8'hFE);
    send(xcrc_pkg::ACT_BYTE, 8'hA5);
    send(xcrc_tb_pkg::ACT_NOP, 8'h00);
    send(xcrc_pkg::ACT_START, 8'h00);
    send(xcrc_pkg::ACT_BYTE, xcrc_pkg::CH_SOH);
    send(xcrc_pkg::ACT_BYTE, 8'h01);
    send(xcrc_pkg::ACT_TIMEOUT, 8'h00);

    write_limit(8'd0);
    send(xcrc_pkg::ACT_START, 8'h00);
    send(xcrc_pkg::ACT_TIMEOUT, 8'h00);
    send(xcrc_pkg::ACT_START, 8'h00);
    send(xcrc_pkg::ACT_BYTE, 8'h55);
    send(xcrc_pkg::ACT_START, 8'h00);
    send(xcrc_pkg::ACT_BYTE, xcrc_pkg::CH_SOH);
    send(xcrc_pkg::ACT_TIMEOUT, 8'h00);

    // fill the result buffer while the receiver holds off
    write_limit(8'd255);
    hold_go = 1'b1;
    gap_max = 0;
    send(xcrc_pkg::ACT_START, 8'h00);
    send_frame(session_block, ~session_block, 1'b0, -1, xcrc_pkg::ACT_TIMEOUT);
    gap_max = 8;
    mix(130);

    write_limit(8'($urandom_range(1, 3)));
    gap_max = 12;
    mix(110);

    write_limit(8'($urandom_range(0, 255)));
    gap_max = 4;
    mix(80);

    drain();
    repeat (4) @(posedge clk);
    if (error_count == 0 && pending_count == 0) begin
      $display("** xmodem_crc_receiver: PASSED **");
    end else begin
      $display("** xmodem_crc_receiver: FAILED **");
    end
    $finish;
  end

endmodule
